FILE: hw/rtl/paged_mmu_frame_allocator_macros.svh
// assertion macros shared by the frame allocator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef PAGED_MMU_FRAME_ALLOCATOR_MACROS_SVH
`define PAGED_MMU_FRAME_ALLOCATOR_MACROS_SVH

// property that must hold at every clock edge out of reset
`define PMFA_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("pmfa check failed");

// implication checked in the cycle after the antecedent
`define PMFA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("pmfa check failed");

`endif

FILE: hw/rtl/pmfa_pkg.sv
// shared types, codes and defaults of the paged mmu frame allocator
// no dependencies
package pmfa_pkg;

    // field widths of the word ports
    localparam int CMD_W   = 3;
    localparam int PID_W   = 8;
    localparam int VADDR_W = 22;
    localparam int CNT_W   = 11;
    localparam int PROT_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int BYTES_W = 23;
    localparam int STAT_W  = 2;

    // default sizing
    localparam int DEF_MAX_PROCS      = 128;
    localparam int DEF_PAGES_PER_PROC = 1024;
    localparam int DEF_NUM_FRAMES     = 1024;
    localparam int DEF_PAGE_BYTES     = 4096;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_EXIT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FORK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEALLOC = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd6;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SEGV    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_SLOT = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NO_FRAME = 2'd3;

    // page table entry layout: flags low, present, frame from bit 4 up
    localparam int ENT_WRITE   = 1;
    localparam int ENT_PRESENT = 3;
    localparam int ENT_FRAME   = 4;

    localparam logic [PROT_W-1:0] FLAG_R  = 3'b001;
    localparam logic [PROT_W-1:0] FLAG_RW = 3'b011;
    localparam logic [PROT_W-1:0] FLAG_RX = 3'b101;

    // sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SLOT_SCAN,
        ST_CREATE_CHK,
        ST_CREATE_NEXT,
        ST_CNT_RD,
        ST_CNT_CHK,
        ST_FORK_CHK,
        ST_FORK_RD,
        ST_FORK_EVAL,
        ST_COPY,
        ST_RANGE_RD,
        ST_RANGE_CHK,
        ST_ALLOC_CHK,
        ST_ALLOC_NEXT,
        ST_DEAL_RD,
        ST_DEAL_WR,
        ST_RW_RD,
        ST_RW_CHK,
        ST_RD_WAIT,
        ST_FR_RD,
        ST_FR_CHK,
        ST_KILL_RD,
        ST_KILL_WR,
        ST_DONE
    } state_t;

    // result word
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PID_W-1:0]  new_pid;
        logic [BYTE_W-1:0] read_byte;
    } res_t;

endpackage

FILE: hw/rtl/pmfa_ram.sv
// single port write, single port read memory with registered read data
// no dependencies
module pmfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/pmfa_core.sv
// command sequencer: slot map, free frame count, walks over the page table,
// frame bitmap and byte memory; uses pmfa_pkg and the assertion macros
`include "paged_mmu_frame_allocator_macros.svh"
module pmfa_core import pmfa_pkg::*; #(
    parameter int MAX_PROCS      = DEF_MAX_PROCS,
    parameter int PAGES_PER_PROC = DEF_PAGES_PER_PROC,
    parameter int NUM_FRAMES     = DEF_NUM_FRAMES,
    parameter int PAGE_BYTES     = DEF_PAGE_BYTES,
    parameter int TA_W  = $clog2(MAX_PROCS * PAGES_PER_PROC),
    parameter int FR_W  = $clog2(NUM_FRAMES),
    parameter int BA_W  = $clog2(NUM_FRAMES * PAGE_BYTES),
    parameter int ENT_W = FR_W + 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    command,
    input  logic [PID_W-1:0]    pid,
    input  logic [VADDR_W-1:0]  vaddr,
    input  logic [CNT_W-1:0]    page_count,
    input  logic [PROT_W-1:0]   prot_flags,
    input  logic [BYTE_W-1:0]   write_byte,
    input  logic [BYTES_W-1:0]  code_bytes,
    input  logic [BYTES_W-1:0]  rodata_bytes,
    input  logic [BYTES_W-1:0]  rwdata_bytes,
    input  logic [BYTES_W-1:0]  stack_bytes,
    output logic                res_valid,
    input  logic                res_ready,
    output res_t                res,
    output logic                tbl_we,
    output logic [TA_W-1:0]     tbl_waddr,
    output logic [ENT_W-1:0]    tbl_wdata,
    output logic [TA_W-1:0]     tbl_raddr,
    input  logic [ENT_W-1:0]    tbl_rdata,
    output logic                frm_we,
    output logic [FR_W-1:0]     frm_waddr,
    output logic [0:0]          frm_wdata,
    output logic [FR_W-1:0]     frm_raddr,
    input  logic [0:0]          frm_rdata,
    output logic                byt_we,
    output logic [BA_W-1:0]     byt_waddr,
    output logic [BYTE_W-1:0]   byt_wdata,
    output logic [BA_W-1:0]     byt_raddr,
    input  logic [BYTE_W-1:0]   byt_rdata
);

    localparam int SLOT_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int PG_W      = $clog2(PAGES_PER_PROC);
    localparam int PGC_W     = $clog2(PAGES_PER_PROC + 1);
    localparam int FRC_W     = $clog2(NUM_FRAMES + 1);
    localparam int OFF_W     = $clog2(PAGE_BYTES);
    localparam int VP_W      = VADDR_W - OFF_W;
    localparam int PB_W      = BYTES_W + 1 - OFF_W;
    localparam int TOT_W     = PB_W + 2;
    localparam int TBL_DEPTH = MAX_PROCS * PAGES_PER_PROC;
    localparam int CLR_N     = (TBL_DEPTH > NUM_FRAMES) ? TBL_DEPTH : NUM_FRAMES;
    localparam int CLR_W     = $clog2(CLR_N);

    state_t               state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [SLOT_W-1:0]    cur_slot_reg, cur_slot_next;
    logic                 pid_ok_reg, pid_ok_next;
    logic [SLOT_W-1:0]    new_slot_reg, new_slot_next;
    logic [SLOT_W-1:0]    map_slot_reg, map_slot_next;
    logic [VP_W-1:0]      vpage_reg, vpage_next;
    logic [OFF_W-1:0]     offset_reg, offset_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [PROT_W-1:0]    prot_reg, prot_next;
    logic [BYTE_W-1:0]    wbyte_reg, wbyte_next;
    logic [TOT_W-1:0]     c_reg, c_next;
    logic [TOT_W-1:0]     cr_reg, cr_next;
    logic [TOT_W-1:0]     crw_reg, crw_next;
    logic [TOT_W-1:0]     total_reg, total_next;
    logic [MAX_PROCS-1:0] slots_reg, slots_next;
    logic [SLOT_W-1:0]    sidx_reg, sidx_next;
    logic [PGC_W-1:0]     idx_reg, idx_next;
    logic [PGC_W-1:0]     need_reg, need_next;
    logic [FR_W-1:0]      fptr_reg, fptr_next;
    logic [FRC_W-1:0]     free_cnt_reg, free_cnt_next;
    logic [CLR_W-1:0]     clr_reg, clr_next;
    logic [PG_W-1:0]      map_page_reg, map_page_next;
    logic [PROT_W-1:0]    map_flags_reg, map_flags_next;
    logic [FR_W-1:0]      src_frame_reg, src_frame_next;
    logic [FR_W-1:0]      dst_frame_reg, dst_frame_next;
    logic [OFF_W:0]       copy_reg, copy_next;
    res_t                 res_reg, res_next;

    logic [FR_W-1:0]      ent_frame;
    logic                 ent_present;
    logic                 ent_write;

    function automatic logic [TA_W-1:0] tbl_addr(input logic [SLOT_W-1:0] s,
                                                 input logic [PG_W-1:0] p);
        tbl_addr = TA_W'(s) * TA_W'(PAGES_PER_PROC) + TA_W'(p);
    endfunction

    function automatic logic [BA_W-1:0] byte_addr(input logic [FR_W-1:0] f,
                                                  input logic [OFF_W-1:0] o);
        byte_addr = BA_W'(f) * BA_W'(PAGE_BYTES) + BA_W'(o);
    endfunction

    function automatic logic [PB_W-1:0] pages_of(input logic [BYTES_W-1:0] b);
        logic [BYTES_W:0] sum;
        sum = {1'b0, b} + (BYTES_W + 1)'(PAGE_BYTES - 1);
        pages_of = sum[BYTES_W:OFF_W];
    endfunction

    // page table entry fields
    assign ent_frame   = tbl_rdata[ENT_W-1:ENT_FRAME];
    assign ent_present = tbl_rdata[ENT_PRESENT];
    assign ent_write   = tbl_rdata[ENT_WRITE];

    assign in_ready = (state_reg == ST_IDLE);
    assign res      = res_reg;

    // state and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            slots_reg    <= '0;
            free_cnt_reg <= FRC_W'(NUM_FRAMES);
            clr_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            slots_reg    <= slots_next;
            free_cnt_reg <= free_cnt_next;
            clr_reg      <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        cur_slot_reg  <= cur_slot_next;
        pid_ok_reg    <= pid_ok_next;
        new_slot_reg  <= new_slot_next;
        map_slot_reg  <= map_slot_next;
        vpage_reg     <= vpage_next;
        offset_reg    <= offset_next;
        count_reg     <= count_next;
        prot_reg      <= prot_next;
        wbyte_reg     <= wbyte_next;
        c_reg         <= c_next;
        cr_reg        <= cr_next;
        crw_reg       <= crw_next;
        total_reg     <= total_next;
        sidx_reg      <= sidx_next;
        idx_reg       <= idx_next;
        need_reg      <= need_next;
        fptr_reg      <= fptr_next;
        map_page_reg  <= map_page_next;
        map_flags_reg <= map_flags_next;
        src_frame_reg <= src_frame_next;
        dst_frame_reg <= dst_frame_next;
        copy_reg      <= copy_next;
        res_reg       <= res_next;
    end

    // next state, memory accesses and result
    always_comb
    begin
        logic [TOT_W-1:0] c_pg, r_pg, w_pg, s_pg;
        logic             live;

        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cur_slot_next  = cur_slot_reg;
        pid_ok_next    = pid_ok_reg;
        new_slot_next  = new_slot_reg;
        map_slot_next  = map_slot_reg;
        vpage_next     = vpage_reg;
        offset_next    = offset_reg;
        count_next     = count_reg;
        prot_next      = prot_reg;
        wbyte_next     = wbyte_reg;
        c_next         = c_reg;
        cr_next        = cr_reg;
        crw_next       = crw_reg;
        total_next     = total_reg;
        slots_next     = slots_reg;
        sidx_next      = sidx_reg;
        idx_next       = idx_reg;
        need_next      = need_reg;
        fptr_next      = fptr_reg;
        free_cnt_next  = free_cnt_reg;
        clr_next       = clr_reg;
        map_page_next  = map_page_reg;
        map_flags_next = map_flags_reg;
        src_frame_next = src_frame_reg;
        dst_frame_next = dst_frame_reg;
        copy_next      = copy_reg;
        res_next       = res_reg;

        tbl_we    = 1'b0;
        tbl_waddr = tbl_addr(cur_slot_reg, PG_W'(idx_reg));
        tbl_wdata = '0;
        tbl_raddr = tbl_addr(cur_slot_reg, PG_W'(idx_reg));
        frm_we    = 1'b0;
        frm_waddr = ent_frame;
        frm_wdata = 1'b0;
        frm_raddr = fptr_reg;
        byt_we    = 1'b0;
        byt_waddr = byte_addr(dst_frame_reg, OFF_W'(copy_reg - 1'b1));
        byt_wdata = byt_rdata;
        byt_raddr = byte_addr(src_frame_reg, OFF_W'(copy_reg));
        res_valid = 1'b0;

        c_pg = TOT_W'(pages_of(code_bytes));
        r_pg = TOT_W'(pages_of(rodata_bytes));
        w_pg = TOT_W'(pages_of(rwdata_bytes));
        s_pg = TOT_W'(pages_of(stack_bytes));
        live = pid_ok_reg && slots_reg[cur_slot_reg];

        unique case (state_reg)
            // zero the page table and frame bitmap after reset
            ST_CLEAR:
            begin
                tbl_we    = (32'(clr_reg) < TBL_DEPTH);
                tbl_waddr = TA_W'(clr_reg);
                frm_we    = (32'(clr_reg) < NUM_FRAMES);
                frm_waddr = FR_W'(clr_reg);
                clr_next  = clr_reg + 1'b1;
                if (32'(clr_reg) == CLR_N - 1)
                begin
                    state_next = ST_IDLE;
                end
            end

            // take a command word and size up a create
            ST_IDLE:
            begin
                cmd_next      = command;
                pid_ok_next   = (pid != '0) && (32'(pid) <= MAX_PROCS);
                cur_slot_next = SLOT_W'(pid - 1'b1);
                vpage_next    = VP_W'(vaddr >> OFF_W);
                offset_next   = OFF_W'(vaddr);
                count_next    = page_count;
                prot_next     = prot_flags;
                wbyte_next    = write_byte;
                c_next        = c_pg;
                cr_next       = c_pg + r_pg;
                crw_next      = c_pg + r_pg + w_pg;
                total_next    = c_pg + r_pg + w_pg + s_pg;
                res_next      = '{status: STAT_OK, new_pid: '0, read_byte: '0};
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                fptr_next = '0;
                idx_next  = '0;
                sidx_next = '0;
                if ((cmd_reg inside {[CMD_EXIT:CMD_WRITE]}) && !live)
                begin
                    res_next.status = STAT_SEGV;
                    state_next      = ST_DONE;
                end
                else
                begin
                    case (cmd_reg)
                        CMD_CREATE, CMD_FORK:
                        begin
                            state_next = ST_SLOT_SCAN;
                        end
                        CMD_EXIT:
                        begin
                            state_next = ST_KILL_RD;
                        end
                        CMD_ALLOC, CMD_DEALLOC:
                        begin
                            if (32'(vpage_reg) + 32'(count_reg) > PAGES_PER_PROC)
                            begin
                                res_next.status = STAT_SEGV;
                                state_next      = ST_KILL_RD;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_RANGE_RD;
                            end
                        end
                        CMD_READ, CMD_WRITE:
                        begin
                            if (32'(vpage_reg) >= PAGES_PER_PROC)
                            begin
                                res_next.status = STAT_SEGV;
                                state_next      = ST_KILL_RD;
                            end
                            else
                            begin
                                state_next = ST_RW_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // lowest free process slot, one per cycle
            ST_SLOT_SCAN:
            begin
                if (!slots_reg[sidx_reg])
                begin
                    new_slot_next = sidx_reg;
                    need_next     = '0;
                    state_next    = (cmd_reg == CMD_CREATE) ? ST_CREATE_CHK : ST_CNT_RD;
                end
                else if (32'(sidx_reg) == MAX_PROCS - 1)
                begin
                    res_next.status = STAT_NO_SLOT;
                    state_next      = ST_DONE;
                end
                else
                begin
                    sidx_next = sidx_reg + 1'b1;
                end
            end

            ST_CREATE_CHK:
            begin
                if (32'(total_reg) > PAGES_PER_PROC)
                begin
                    res_next.status = STAT_SEGV;
                    state_next      = ST_DONE;
                end
                else if (32'(total_reg) > 32'(free_cnt_reg))
                begin
                    res_next.status = STAT_NO_FRAME;
                    state_next      = ST_DONE;
                end
                else
                begin
                    slots_next[new_slot_reg] = 1'b1;
                    map_slot_next            = new_slot_reg;
                    res_next.new_pid         = PID_W'(32'(new_slot_reg) + 1);
                    state_next               = ST_CREATE_NEXT;
                end
            end

            // code, rodata, rwdata from page 0, stack at the top
            ST_CREATE_NEXT:
            begin
                if (32'(idx_reg) == 32'(total_reg))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    if (32'(idx_reg) < 32'(crw_reg))
                    begin
                        map_page_next = PG_W'(idx_reg);
                    end
                    else
                    begin
                        map_page_next = PG_W'(PAGES_PER_PROC - 32'(total_reg)
                                              + 32'(idx_reg));
                    end
                    if (32'(idx_reg) < 32'(c_reg))
                    begin
                        map_flags_next = FLAG_RX;
                    end
                    else if (32'(idx_reg) < 32'(cr_reg))
                    begin
                        map_flags_next = FLAG_R;
                    end
                    else
                    begin
                        map_flags_next = FLAG_RW;
                    end
                    state_next = ST_FR_RD;
                end
            end

            // count present pages of the parent
            ST_CNT_RD:
            begin
                state_next = ST_CNT_CHK;
            end

            ST_CNT_CHK:
            begin
                need_next = need_reg + PGC_W'(ent_present);
                if (32'(idx_reg) == PAGES_PER_PROC - 1)
                begin
                    state_next = ST_FORK_CHK;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_CNT_RD;
                end
            end

            ST_FORK_CHK:
            begin
                idx_next = '0;
                if (32'(need_reg) > 32'(free_cnt_reg))
                begin
                    res_next.status = STAT_NO_FRAME;
                    state_next      = ST_KILL_RD;
                end
                else
                begin
                    slots_next[new_slot_reg] = 1'b1;
                    map_slot_next            = new_slot_reg;
                    res_next.new_pid         = PID_W'(32'(new_slot_reg) + 1);
                    state_next               = ST_FORK_RD;
                end
            end

            ST_FORK_RD:
            begin
                if (32'(idx_reg) == PAGES_PER_PROC)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_FORK_EVAL;
                end
            end

            ST_FORK_EVAL:
            begin
                if (ent_present)
                begin
                    map_page_next  = PG_W'(idx_reg);
                    map_flags_next = tbl_rdata[PROT_W-1:0];
                    src_frame_next = ent_frame;
                    state_next     = ST_FR_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_FORK_RD;
                end
            end

            // byte copy, read one ahead of the write
            ST_COPY:
            begin
                byt_we    = (copy_reg != '0);
                copy_next = copy_reg + 1'b1;
                if (32'(copy_reg) == PAGE_BYTES)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_FORK_RD;
                end
            end

            // presence check over the allocate or deallocate range
            ST_RANGE_RD:
            begin
                tbl_raddr  = tbl_addr(cur_slot_reg, PG_W'(32'(vpage_reg) + 32'(idx_reg)));
                state_next = ST_RANGE_CHK;
            end

            ST_RANGE_CHK:
            begin
                if (ent_present == (cmd_reg == CMD_ALLOC))
                begin
                    res_next.status = STAT_SEGV;
                    idx_next        = '0;
                    state_next      = ST_KILL_RD;
                end
                else if (32'(idx_reg) + 1 == 32'(count_reg))
                begin
                    idx_next   = '0;
                    state_next = (cmd_reg == CMD_ALLOC) ? ST_ALLOC_CHK : ST_DEAL_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RANGE_RD;
                end
            end

            ST_ALLOC_CHK:
            begin
                map_slot_next = cur_slot_reg;
                if (32'(count_reg) > 32'(free_cnt_reg))
                begin
                    res_next.status = STAT_NO_FRAME;
                    state_next      = ST_KILL_RD;
                end
                else
                begin
                    state_next = ST_ALLOC_NEXT;
                end
            end

            ST_ALLOC_NEXT:
            begin
                if (32'(idx_reg) == 32'(count_reg))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    map_page_next  = PG_W'(32'(vpage_reg) + 32'(idx_reg));
                    map_flags_next = prot_reg;
                    state_next     = ST_FR_RD;
                end
            end

            ST_DEAL_RD:
            begin
                tbl_raddr  = tbl_addr(cur_slot_reg, PG_W'(32'(vpage_reg) + 32'(idx_reg)));
                state_next = ST_DEAL_WR;
            end

            ST_DEAL_WR:
            begin
                frm_we        = 1'b1;
                free_cnt_next = free_cnt_reg + 1'b1;
                tbl_we        = 1'b1;
                tbl_waddr     = tbl_addr(cur_slot_reg, PG_W'(32'(vpage_reg) + 32'(idx_reg)));
                if (32'(idx_reg) + 1 == 32'(count_reg))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_DEAL_RD;
                end
            end

            // single byte access through the table
            ST_RW_RD:
            begin
                tbl_raddr  = tbl_addr(cur_slot_reg, PG_W'(vpage_reg));
                state_next = ST_RW_CHK;
            end

            ST_RW_CHK:
            begin
                byt_raddr = byte_addr(ent_frame, offset_reg);
                byt_waddr = byte_addr(ent_frame, offset_reg);
                byt_wdata = wbyte_reg;
                if (!ent_present || ((cmd_reg == CMD_WRITE) && !ent_write))
                begin
                    res_next.status = STAT_SEGV;
                    idx_next        = '0;
                    state_next      = ST_KILL_RD;
                end
                else if (cmd_reg == CMD_WRITE)
                begin
                    byt_we     = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_RD_WAIT;
                end
            end

            ST_RD_WAIT:
            begin
                res_next.read_byte = byt_rdata;
                state_next         = ST_DONE;
            end

            // lowest free frame: probe the bitmap, claim on a hit
            ST_FR_RD:
            begin
                state_next = ST_FR_CHK;
            end

            ST_FR_CHK:
            begin
                fptr_next = fptr_reg + 1'b1;
                if (!frm_rdata[0])
                begin
                    frm_we         = 1'b1;
                    frm_waddr      = fptr_reg;
                    frm_wdata      = 1'b1;
                    tbl_we         = 1'b1;
                    tbl_waddr      = tbl_addr(map_slot_reg, map_page_reg);
                    tbl_wdata      = {fptr_reg, 1'b1, map_flags_reg};
                    free_cnt_next  = free_cnt_reg - 1'b1;
                    dst_frame_next = fptr_reg;
                    case (cmd_reg)
                        CMD_CREATE:
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = ST_CREATE_NEXT;
                        end
                        CMD_FORK:
                        begin
                            copy_next  = '0;
                            state_next = ST_COPY;
                        end
                        default:
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = ST_ALLOC_NEXT;
                        end
                    endcase
                end
                else
                begin
                    state_next = ST_FR_RD;
                end
            end

            // tear down the current process, one page per pass through the read and write states
            ST_KILL_RD:
            begin
                state_next = ST_KILL_WR;
            end

            ST_KILL_WR:
            begin
                tbl_we = 1'b1;
                if (ent_present)
                begin
                    frm_we        = 1'b1;
                    free_cnt_next = free_cnt_reg + 1'b1;
                end
                if (32'(idx_reg) == PAGES_PER_PROC - 1)
                begin
                    slots_next[cur_slot_reg] = 1'b0;
                    state_next               = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_KILL_RD;
                end
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `PMFA_ASSERT(a_free_bound, clk, rst_n, 32'(free_cnt_reg) <= NUM_FRAMES)
    `PMFA_ASSERT(a_take_free, clk, rst_n, !(frm_we && frm_wdata[0]) || !frm_rdata[0])
    `PMFA_ASSERT(a_res_room, clk, rst_n, !res_valid || res_ready)
    `PMFA_ASSERT_NEXT(a_accept_decode, clk, rst_n, in_valid && in_ready, state_reg == ST_DECODE)

endmodule

FILE: hw/rtl/paged_mmu_frame_allocator.sv
// Paged memory manager: process slots, per-process page tables, frame bitmap, byte store.
// One command at a time. Allocate/deallocate check each page of the range, then probe the
// bitmap for a frame per page claimed or free the frame of each page. Exit and kills clear
// every table page; fork counts the parent's present pages and copies each one bytewise.
// After reset, a clearing pass over MAX_PROCS*PAGES_PER_PROC table entries (131072 by
// default) and the frame bitmap zeroes both; no input word is taken until it ends.
module paged_mmu_frame_allocator import pmfa_pkg::*; #(
    parameter int MAX_PROCS      = DEF_MAX_PROCS,
    parameter int PAGES_PER_PROC = DEF_PAGES_PER_PROC,
    parameter int NUM_FRAMES     = DEF_NUM_FRAMES,
    parameter int PAGE_BYTES     = DEF_PAGE_BYTES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CMD_W-1:0]   command,
    input  logic [PID_W-1:0]   pid,
    input  logic [VADDR_W-1:0] vaddr,
    input  logic [CNT_W-1:0]   page_count,
    input  logic [PROT_W-1:0]  prot_flags,
    input  logic [BYTE_W-1:0]  write_byte,
    input  logic [BYTES_W-1:0] code_bytes,
    input  logic [BYTES_W-1:0] rodata_bytes,
    input  logic [BYTES_W-1:0] rwdata_bytes,
    input  logic [BYTES_W-1:0] stack_bytes,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [STAT_W-1:0]  status,
    output logic [PID_W-1:0]   new_pid,
    output logic [BYTE_W-1:0]  read_byte
);

    localparam int TBL_DEPTH  = MAX_PROCS * PAGES_PER_PROC;
    localparam int BYTE_DEPTH = NUM_FRAMES * PAGE_BYTES;
    localparam int TA_W       = $clog2(TBL_DEPTH);
    localparam int FR_W       = $clog2(NUM_FRAMES);
    localparam int BA_W       = $clog2(BYTE_DEPTH);
    localparam int ENT_W      = FR_W + 4;

    logic              res_valid;
    logic              res_ready;
    res_t              res;
    res_t              out_reg;
    logic              out_valid_reg;

    logic              tbl_we;
    logic [TA_W-1:0]   tbl_waddr;
    logic [ENT_W-1:0]  tbl_wdata;
    logic [TA_W-1:0]   tbl_raddr;
    logic [ENT_W-1:0]  tbl_rdata;
    logic              frm_we;
    logic [FR_W-1:0]   frm_waddr;
    logic [0:0]        frm_wdata;
    logic [FR_W-1:0]   frm_raddr;
    logic [0:0]        frm_rdata;
    logic              byt_we;
    logic [BA_W-1:0]   byt_waddr;
    logic [BYTE_W-1:0] byt_wdata;
    logic [BA_W-1:0]   byt_raddr;
    logic [BYTE_W-1:0] byt_rdata;

    // sequencer
    pmfa_core #(
        .MAX_PROCS      (MAX_PROCS),
        .PAGES_PER_PROC (PAGES_PER_PROC),
        .NUM_FRAMES     (NUM_FRAMES),
        .PAGE_BYTES     (PAGE_BYTES),
        .TA_W           (TA_W),
        .FR_W           (FR_W),
        .BA_W           (BA_W),
        .ENT_W          (ENT_W)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .pid          (pid),
        .vaddr        (vaddr),
        .page_count   (page_count),
        .prot_flags   (prot_flags),
        .write_byte   (write_byte),
        .code_bytes   (code_bytes),
        .rodata_bytes (rodata_bytes),
        .rwdata_bytes (rwdata_bytes),
        .stack_bytes  (stack_bytes),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .tbl_we       (tbl_we),
        .tbl_waddr    (tbl_waddr),
        .tbl_wdata    (tbl_wdata),
        .tbl_raddr    (tbl_raddr),
        .tbl_rdata    (tbl_rdata),
        .frm_we       (frm_we),
        .frm_waddr    (frm_waddr),
        .frm_wdata    (frm_wdata),
        .frm_raddr    (frm_raddr),
        .frm_rdata    (frm_rdata),
        .byt_we       (byt_we),
        .byt_waddr    (byt_waddr),
        .byt_wdata    (byt_wdata),
        .byt_raddr    (byt_raddr),
        .byt_rdata    (byt_rdata)
    );

    // page tables of all slots
    pmfa_ram #(.WIDTH(ENT_W), .DEPTH(TBL_DEPTH), .AW(TA_W)) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // frame use bitmap
    pmfa_ram #(.WIDTH(1), .DEPTH(NUM_FRAMES), .AW(FR_W)) u_frames (
        .clk   (clk),
        .we    (frm_we),
        .waddr (frm_waddr),
        .wdata (frm_wdata),
        .raddr (frm_raddr),
        .rdata (frm_rdata)
    );

    // physical byte store
    pmfa_ram #(.WIDTH(BYTE_W), .DEPTH(BYTE_DEPTH), .AW(BA_W)) u_bytes (
        .clk   (clk),
        .we    (byt_we),
        .waddr (byt_waddr),
        .wdata (byt_wdata),
        .raddr (byt_raddr),
        .rdata (byt_rdata)
    );

    // result word register
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_reg.status;
    assign new_pid   = out_reg.new_pid;
    assign read_byte = out_reg.read_byte;

endmodule

FILE: tb/pmfa_scoreboard.sv
// checker for the paged mmu frame allocator: watches both word channels,
// predicts each result from its own process, page and frame model, compares
// depends on pmfa_pkg only
`timescale 1ns / 100ps

module pmfa_scoreboard import pmfa_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [CMD_W-1:0]   command,
    input  logic [PID_W-1:0]   pid,
    input  logic [VADDR_W-1:0] vaddr,
    input  logic [CNT_W-1:0]   page_count,
    input  logic [PROT_W-1:0]  prot_flags,
    input  logic [BYTE_W-1:0]  write_byte,
    input  logic [BYTES_W-1:0] code_bytes,
    input  logic [BYTES_W-1:0] rodata_bytes,
    input  logic [BYTES_W-1:0] rwdata_bytes,
    input  logic [BYTES_W-1:0] stack_bytes,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [STAT_W-1:0]  status,
    input  logic [PID_W-1:0]   new_pid,
    input  logic [BYTE_W-1:0]  read_byte,
    output int                 fail_count,
    output int                 outstanding
);

    localparam int NPROC  = DEF_MAX_PROCS;
    localparam int NPAGE  = DEF_PAGES_PER_PROC;
    localparam int NFRAME = DEF_NUM_FRAMES;
    localparam int PBYTES = DEF_PAGE_BYTES;

    // shadow state of the block
    bit          proc_live  [0:NPROC-1];
    bit [13:0]   pte        [0:NPROC*NPAGE-1];
    bit          frame_used [0:NFRAME-1];
    bit [7:0]    phys_mem   [0:NFRAME*PBYTES-1];
    bit          phys_set   [0:NFRAME*PBYTES-1];

    res_t        expected_q [$];

    // helpers also used by the stimulus side to shape legal traffic
    function automatic bit slot_live(int p);
        return (p >= 1 && p <= NPROC) ? proc_live[p-1] : 1'b0;
    endfunction

    function automatic bit [13:0] entry_of(int p, int page);
        return pte[(p-1)*NPAGE + page];
    endfunction

    function automatic int frames_free();
        int n;
        n = 0;
        for (int i = 0; i < NFRAME; i++)
            if (!frame_used[i]) n++;
        return n;
    endfunction

    function automatic int present_pages(int p);
        int n;
        n = 0;
        for (int i = 0; i < NPAGE; i++)
            if (pte[(p-1)*NPAGE + i][ENT_PRESENT]) n++;
        return n;
    endfunction

    function automatic bit readable(int p, int va);
        bit [13:0] e;
        e = entry_of(p, va / PBYTES);
        return e[ENT_PRESENT] && phys_set[int'(e[13:4])*PBYTES + va % PBYTES];
    endfunction

    function automatic int grab_frame();
        for (int i = 0; i < NFRAME; i++)
            if (!frame_used[i])
            begin
                frame_used[i] = 1'b1;
                return i;
            end
        return 0;
    endfunction

    function automatic void map_into(int idx, logic [2:0] flags);
        int f;
        f = grab_frame();
        pte[idx] = {f[9:0], 1'b1, flags};
    endfunction

    function automatic void drop_proc(int slot);
        for (int i = 0; i < NPAGE; i++)
        begin
            if (pte[slot*NPAGE + i][ENT_PRESENT])
                frame_used[pte[slot*NPAGE + i][13:4]] = 1'b0;
            pte[slot*NPAGE + i] = '0;
        end
        proc_live[slot] = 1'b0;
    endfunction

    function automatic int lowest_free_slot();
        for (int i = 0; i < NPROC; i++)
            if (!proc_live[i]) return i;
        return -1;
    endfunction

    function automatic int bytes_to_pages(logic [BYTES_W-1:0] b);
        return (int'(b) + PBYTES - 1) / PBYTES;
    endfunction

    // advance the shadow state by one command word and give its result
    function automatic res_t apply_command();
        res_t r;
        int   slot, base, page, off, ns, need, c, ro, rw, st, p, e, src, dst;
        bit   bad, live_ok;
        logic [CMD_W-1:0] op;
        r = '0;
        op = command;
        page = vaddr / PBYTES;
        off = vaddr % PBYTES;
        slot = pid - 1;
        base = slot * NPAGE;
        live_ok = slot_live(pid);
        if (op != CMD_CREATE && op <= CMD_WRITE && !live_ok)
        begin
            r.status = STAT_SEGV;
            return r;
        end
        case (op)
            CMD_CREATE:
            begin
                c = bytes_to_pages(code_bytes);
                ro = bytes_to_pages(rodata_bytes);
                rw = bytes_to_pages(rwdata_bytes);
                st = bytes_to_pages(stack_bytes);
                ns = lowest_free_slot();
                if (ns < 0) r.status = STAT_NO_SLOT;
                else if (c + ro + rw + st > NPAGE) r.status = STAT_SEGV;
                else if (c + ro + rw + st > frames_free()) r.status = STAT_NO_FRAME;
                else
                begin
                    proc_live[ns] = 1'b1;
                    p = 0;
                    for (int i = 0; i < c; i++) map_into(ns*NPAGE + p++, FLAG_RX);
                    for (int i = 0; i < ro; i++) map_into(ns*NPAGE + p++, FLAG_R);
                    for (int i = 0; i < rw; i++) map_into(ns*NPAGE + p++, FLAG_RW);
                    for (int i = 0; i < st; i++)
                        map_into(ns*NPAGE + NPAGE - st + i, FLAG_RW);
                    r.new_pid = ns + 1;
                end
            end
            CMD_EXIT: drop_proc(slot);
            CMD_FORK:
            begin
                ns = lowest_free_slot();
                need = present_pages(pid);
                if (ns < 0) r.status = STAT_NO_SLOT;
                else if (need > frames_free())
                begin
                    r.status = STAT_NO_FRAME;
                    drop_proc(slot);
                end
                else
                begin
                    proc_live[ns] = 1'b1;
                    for (int i = 0; i < NPAGE; i++)
                    begin
                        pte[ns*NPAGE + i] = '0;
                        if (pte[base + i][ENT_PRESENT])
                        begin
                            src = pte[base + i][13:4];
                            dst = grab_frame();
                            pte[ns*NPAGE + i] = {dst[9:0], pte[base + i][3:0]};
                            for (int b = 0; b < PBYTES; b++)
                            begin
                                phys_mem[dst*PBYTES + b] = phys_mem[src*PBYTES + b];
                                phys_set[dst*PBYTES + b] = phys_set[src*PBYTES + b];
                            end
                        end
                    end
                    r.new_pid = ns + 1;
                end
            end
            CMD_ALLOC, CMD_DEALLOC:
            begin
                bad = page + page_count > NPAGE;
                for (int i = 0; !bad && i < page_count; i++)
                    if (pte[base + page + i][ENT_PRESENT] == (op == CMD_ALLOC))
                        bad = 1'b1;
                if (bad)
                begin
                    r.status = STAT_SEGV;
                    drop_proc(slot);
                end
                else if (op == CMD_ALLOC)
                begin
                    if (page_count > frames_free())
                    begin
                        r.status = STAT_NO_FRAME;
                        drop_proc(slot);
                    end
                    else
                        for (int i = 0; i < page_count; i++)
                            map_into(base + page + i, prot_flags);
                end
                else
                    for (int i = 0; i < page_count; i++)
                    begin
                        frame_used[pte[base + page + i][13:4]] = 1'b0;
                        pte[base + page + i] = '0;
                    end
            end
            CMD_READ, CMD_WRITE:
            begin
                e = pte[base + page];
                if (!e[ENT_PRESENT] || (op == CMD_WRITE && !e[ENT_WRITE]))
                begin
                    r.status = STAT_SEGV;
                    drop_proc(slot);
                end
                else if (op == CMD_READ)
                    r.read_byte = phys_mem[(e >> ENT_FRAME)*PBYTES + off];
                else
                begin
                    phys_mem[(e >> ENT_FRAME)*PBYTES + off] = write_byte;
                    phys_set[(e >> ENT_FRAME)*PBYTES + off] = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // compare result words first, then predict the newly accepted command
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NPROC; i++) proc_live[i] = 1'b0;
            for (int i = 0; i < NPROC*NPAGE; i++) pte[i] = '0;
            for (int i = 0; i < NFRAME; i++) frame_used[i] = 1'b0;
            expected_q.delete();
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("result word with nothing expected: %0d %0d %0d",
                                 status, new_pid, read_byte);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (status !== want.status || new_pid !== want.new_pid ||
                        read_byte !== want.read_byte)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected st %0d pid %0d byte %0d, got %0d %0d %0d",
                                     want.status, want.new_pid, want.read_byte,
                                     status, new_pid, read_byte);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(apply_command());
            outstanding = expected_q.size();
        end
    end

endmodule

FILE: tb/tb_paged_mmu_frame_allocator.sv
// top of the frame allocator testbench: clock, reset, command words, result drain
// depends on pmfa_pkg, paged_mmu_frame_allocator and pmfa_scoreboard
`timescale 1ns / 100ps

module tb_paged_mmu_frame_allocator;
    import pmfa_pkg::*;

    localparam int N_DIRECTED = 30;
    localparam int N_WORDS    = 1350;
    localparam int STALL_LIMIT = 400000;
    localparam int PB = DEF_PAGE_BYTES;

    typedef struct {
        logic [CMD_W-1:0]   op;
        logic [PID_W-1:0]   id;
        logic [VADDR_W-1:0] va;
        logic [CNT_W-1:0]   cnt;
        logic [PROT_W-1:0]  prot;
        logic [BYTE_W-1:0]  wb;
        logic [BYTES_W-1:0] cb, rb, wdb, sb;
    } cmd_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [CMD_W-1:0]   command;
    logic [PID_W-1:0]   pid;
    logic [VADDR_W-1:0] vaddr;
    logic [CNT_W-1:0]   page_count;
    logic [PROT_W-1:0]  prot_flags;
    logic [BYTE_W-1:0]  write_byte;
    logic [BYTES_W-1:0] code_bytes, rodata_bytes, rwdata_bytes, stack_bytes;
    logic [STAT_W-1:0]  status;
    logic [PID_W-1:0]   new_pid;
    logic [BYTE_W-1:0]  read_byte;
    int fail_count, outstanding;
    int idle_cycles;
    int recent_pid [$];
    int recent_va  [$];

    paged_mmu_frame_allocator dut (.*);

    pmfa_scoreboard chk (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // blank word, fields zero
    function automatic cmd_word_t blank(logic [CMD_W-1:0] op, int id);
        cmd_word_t w;
        w = '{default: '0};
        w.op = op;
        w.id = id;
        return w;
    endfunction

    function automatic cmd_word_t mk_create(int c, int r, int w, int s);
        cmd_word_t x;
        x = blank(CMD_CREATE, 0);
        x.cb = c; x.rb = r; x.wdb = w; x.sb = s;
        return x;
    endfunction

    function automatic cmd_word_t mk_mem(logic [CMD_W-1:0] op, int id, int va, int b);
        cmd_word_t x;
        x = blank(op, id);
        x.va = va;
        x.wb = b;
        return x;
    endfunction

    function automatic cmd_word_t mk_range(logic [CMD_W-1:0] op, int id, int va, int n, int pr);
        cmd_word_t x;
        x = blank(op, id);
        x.va = va; x.cnt = n; x.prot = pr;
        return x;
    endfunction

    // directed opening: extremes, every command, and segfault paths
    function automatic cmd_word_t directed_word(int n);
        cmd_word_t x;
        case (n)
            0:  x = mk_create(1, 4097, 4096, 8192);
            1:  x = mk_mem(CMD_WRITE, 1, 22'h3FFFFF, 8'hFF);
            2:  x = mk_mem(CMD_READ, 1, 22'h3FFFFF, 0);
            3:  x = mk_mem(CMD_WRITE, 1, 22'h003000, 8'h00);
            4:  x = mk_mem(CMD_READ, 1, 22'h003000, 0);
            5:  x = blank(CMD_FORK, 1);
            6:  x = mk_mem(CMD_READ, 2, 22'h3FFFFF, 0);
            7:  x = mk_range(CMD_ALLOC, 2, 22'h100123, 2, 7);
            8:  x = mk_mem(CMD_WRITE, 2, 22'h100ABC, 8'h5A);
            9:  x = mk_range(CMD_DEALLOC, 2, 22'h101000, 1, 0);
            10: x = mk_range(CMD_DEALLOC, 2, 22'h101000, 1, 0);
            11: x = mk_range(CMD_ALLOC, 1, 22'h3FF000, 2, 3);
            12: x = blank(CMD_EXIT, 0);
            13: x = mk_mem(CMD_READ, 255, 0, 0);
            14: x = mk_mem(CMD_WRITE, 129, 0, 1);
            15: x = blank(CMD_FORK, 5);
            16:
            begin
                x = blank(CMD_WRITE, 0);
                x.op = 3'd7;
                x.va = $urandom;
                x.wb = $urandom;
            end
            17: x = mk_create(4194304, 0, 0, 0);
            18: x = mk_create(0, 0, 0, 0);
            19: x = mk_create(0, 1, 0, 0);
            20: x = mk_create(4194304, 1, 0, 0);
            21: x = blank(CMD_FORK, 1);
            22: x = mk_range(CMD_ALLOC, 2, 0, 0, 1);
            23: x = mk_range(CMD_ALLOC, 2, 0, 1025, 1);
            24: x = mk_create(0, 1, 0, 0);
            25: x = mk_mem(CMD_WRITE, 1, 22'h000010, 8'h33);
            26: x = mk_create(0, 0, 1020 * PB, 0);
            27: x = mk_create(0, 0, 0, 0);
            28: x = mk_range(CMD_ALLOC, 2, 22'h010000, 10, 3);
            default: x = blank(CMD_EXIT, 1);
        endcase
        return x;
    endfunction

    function automatic int pick_live(output int live_n);
        int ids [$];
        for (int p = 1; p <= DEF_MAX_PROCS; p++)
            if (chk.slot_live(p)) ids.push_back(p);
        live_n = ids.size();
        return live_n == 0 ? 0 : ids[$urandom_range(0, live_n - 1)];
    endfunction

    // random page of a process holding the wanted flag bit, or -1
    function automatic int pick_page(int id, int need_bit);
        int pages [$];
        bit [13:0] e;
        for (int i = 0; i < DEF_PAGES_PER_PROC; i++)
        begin
            e = chk.entry_of(id, i);
            if (e[ENT_PRESENT] && e[need_bit]) pages.push_back(i);
        end
        return pages.size() == 0 ? -1 : pages[$urandom_range(0, pages.size() - 1)];
    endfunction

    function automatic int seg_bytes(bit big);
        if (big) return $urandom_range(100, 500) * PB - $urandom_range(0, PB - 1);
        return $urandom_range(0, 2 * PB);
    endfunction

    function automatic cmd_word_t random_word(int n);
        cmd_word_t x;
        int r, id, live_n, pg, tries, start, len, va;
        bit fill, found, big;
        id = pick_live(live_n);
        fill = n >= 500 && n < 700;
        r = $urandom_range(0, 99);
        if (fill && r < 85)
            return mk_create(0, $urandom_range(0, 1), 0, 0);
        if (id == 0 && r >= 4) r = 10;
        if (r < 4)
        begin
            // noise: any bits anywhere
            x.op = $urandom_range(0, 7);
            x.id = $urandom_range(0, 255);
            x.va = $urandom; x.cnt = $urandom; x.prot = $urandom; x.wb = $urandom;
            x.cb = $urandom; x.rb = $urandom; x.wdb = $urandom; x.sb = $urandom;
            return x;
        end
        if (r < 16)
        begin
            big = $urandom_range(0, 9) == 0;
            case ($urandom_range(0, 3))
                0: return mk_create(seg_bytes(big), seg_bytes(0), seg_bytes(0), seg_bytes(0));
                1: return mk_create(seg_bytes(0), seg_bytes(big), seg_bytes(0), seg_bytes(0));
                2: return mk_create(seg_bytes(0), seg_bytes(0), seg_bytes(big), seg_bytes(0));
                default: return mk_create(seg_bytes(0), seg_bytes(0), seg_bytes(0),
                                          seg_bytes(big));
            endcase
        end
        if (r < (live_n > 12 ? 32 : 21))
            return blank(CMD_EXIT, id);
        if (r < 23 && chk.present_pages(id) <= 4)
            return blank(CMD_FORK, id);
        if (r < 38)
        begin
            // mostly a free run of pages
            found = 0;
            len = $urandom_range(0, 19) == 0 ? $urandom_range(0, 40) : $urandom_range(1, 3);
            for (tries = 0; tries < 8 && !found; tries++)
            begin
                start = $urandom_range(0, DEF_PAGES_PER_PROC - 1);
                found = start + len <= DEF_PAGES_PER_PROC;
                for (int i = 0; found && i < len; i++)
                    if (chk.entry_of(id, start + i) >> ENT_PRESENT & 1) found = 0;
            end
            if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 2047);
            return mk_range(CMD_ALLOC, id, start * PB + $urandom_range(0, PB - 1), len,
                            $urandom_range(0, 7));
        end
        if (r < 48)
        begin
            pg = pick_page(id, ENT_PRESENT);
            if (pg < 0 || $urandom_range(0, 9) == 0) pg = $urandom_range(0, 1023);
            len = 1;
            while (len < 3 && pg + len < DEF_PAGES_PER_PROC &&
                   (chk.entry_of(id, pg + len) >> ENT_PRESENT & 1))
                len++;
            return mk_range(CMD_DEALLOC, id, pg * PB + $urandom_range(0, PB - 1),
                            $urandom_range(1, len), 0);
        end
        if (r < 72 || recent_pid.size() == 0)
        begin
            pg = pick_page(id, ENT_WRITE);
            if (pg < 0 || $urandom_range(0, 14) == 0) pg = $urandom_range(0, 1023);
            va = pg * PB + $urandom_range(0, PB - 1);
            recent_pid.push_back(id);
            recent_va.push_back(va);
            if (recent_pid.size() > 64)
            begin
                recent_pid.delete(0);
                recent_va.delete(0);
            end
            return mk_mem(CMD_WRITE, id, va, $urandom_range(0, 255));
        end
        // read only bytes known to hold data, or a page that faults, else exit
        tries = $urandom_range(0, recent_pid.size() - 1);
        if (chk.slot_live(recent_pid[tries]) && chk.readable(recent_pid[tries], recent_va[tries]))
            return mk_mem(CMD_READ, recent_pid[tries], recent_va[tries], $urandom);
        pg = $urandom_range(0, 1023);
        if (!(chk.entry_of(id, pg) >> ENT_PRESENT & 1) && $urandom_range(0, 3) == 0)
            return mk_mem(CMD_READ, id, pg * PB + $urandom_range(0, PB - 1), 0);
        return blank(CMD_EXIT, id);
    endfunction

    // command word sender
    initial
    begin
        cmd_word_t w;
        int gap;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        command <= '0; pid <= '0; vaddr <= '0; page_count <= '0; prot_flags <= '0;
        write_byte <= '0; code_bytes <= '0; rodata_bytes <= '0;
        rwdata_bytes <= '0; stack_bytes <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        for (int n = 0; n < N_WORDS; n++)
        begin
            gap = ((n / 100) % 4 == 3) ? 0 : $urandom_range(0, 6);
            repeat (gap) @(posedge clk);
            @(negedge clk);
            w = n < N_DIRECTED ? directed_word(n) : random_word(n);
            @(posedge clk);
            in_valid <= 1'b1;
            command <= w.op; pid <= w.id; vaddr <= w.va; page_count <= w.cnt;
            prot_flags <= w.prot; write_byte <= w.wb; code_bytes <= w.cb;
            rodata_bytes <= w.rb; rwdata_bytes <= w.wdb; stack_bytes <= w.sb;
            do @(posedge clk); while (!(in_valid && in_ready));
            in_valid <= 1'b0;
        end
        do @(posedge clk); while (outstanding != 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // result word receiver, with one long hold-off to back up the input side
    initial
    begin
        int wait_n, taken;
        taken = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_n = ((taken / 150) % 3 == 2) ? 0 : $urandom_range(0, 6);
            if (taken == 200) wait_n = 400;
            if (wait_n > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            taken++;
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

FILE: paged_mmu_frame_allocator.f
+incdir+hw/rtl
hw/rtl/pmfa_pkg.sv
hw/rtl/pmfa_ram.sv
hw/rtl/pmfa_core.sv
hw/rtl/paged_mmu_frame_allocator.sv
tb/pmfa_scoreboard.sv
tb/tb_paged_mmu_frame_allocator.sv
